// ===== hdl/pit_pkg.sv =====
// ============================================================================
// pit_pkg
// Shared widths, item types and helpers for the point-in-triangle test.
// ============================================================================
`default_nettype none

package pit_pkg;

   // Input geometry: three signed components per vector, x in the low bits.
   localparam int CB         = 20;
   localparam int F          = 16;
   localparam int FIELD_W    = 60;
   localparam int NUM_FIELDS = 5;
   localparam int REQ_W      = 304;
   localparam int RSP_W      = 8;

   // Datapath widths.
   localparam int DW  = CB + 1;          // vertex differences
   localparam int PW  = 2 * DW;          // difference products
   localparam int NW  = PW + 1;          // numerator and denominator of u
   localparam int MW  = NW;              // magnitudes fed to the divider
   localparam int QW  = F + 2;           // magnitude of u, saturated at 2.0
   localparam int UCW = QW + 1 + DW;     // u times an edge component
   localparam int VW  = UCW + 1;         // numerator of v
   localparam int PRW = QW + DW;         // bound product for the u+v test

   // Request queue between the front and the back.
   localparam int QDEPTH = 4;
   localparam int QAW    = 2;

   // Axis codes.
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam logic [QW-1:0] ONE_Q   = {2'b01, {F{1'b0}}};
   localparam logic [QW-1:0] SAT_MAG = {2'b10, {F{1'b0}}};

   // Classified request: projected differences and the flat edge mark.
   typedef struct packed {
      logic                 flat;
      logic signed [DW-1:0] d1;
      logic signed [DW-1:0] d2;
      logic signed [DW-1:0] b1;
      logic signed [DW-1:0] b2;
      logic signed [DW-1:0] c1;
      logic signed [DW-1:0] c2;
   } item_type;

   // What the v test needs, carried alongside the divider.
   typedef struct packed {
      logic signed [DW-1:0] d;
      logic signed [DW-1:0] c;
      logic signed [DW-1:0] b;
      logic                 flat_b0;
      logic                 neg;
      logic                 dz;
   } vctx_type;

   function automatic logic signed [CB-1:0] comp(input logic [FIELD_W-1:0] w,
                                                 input logic [1:0] k);
      logic signed [CB-1:0] r;
      unique case (k)
         AXIS_X:  r = w[CB-1:0];
         AXIS_Y:  r = w[2*CB-1:CB];
         default: r = w[3*CB-1:2*CB];
      endcase
      return r;
   endfunction

   function automatic logic signed [DW-1:0] sub(input logic signed [CB-1:0] a,
                                                input logic signed [CB-1:0] b);
      return {a[CB-1], a} - {b[CB-1], b};
   endfunction

endpackage

`default_nettype wire

// ===== hdl/pit_front.sv =====
// ============================================================================
// pit_front
// Holds an accepted request, picks the projection axes and forms differences.
// ============================================================================
`default_nettype none

module pit_front import pit_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,
   output logic                  push_valid,
   input  wire logic             push_ready,
   output item_type              push_item
);

   logic                            hold_valid_ff;
   logic [NUM_FIELDS*FIELD_W-1:0]   hold_data_ff;
   logic [FIELD_W-1:0]              nrm, va, vb, vc, vp;
   logic [CB-1:0]                   n0, n1, n2;
   logic [1:0]                      ax, i1, i2;

   assign req_tready = !hold_valid_ff || push_ready;
   assign push_valid = hold_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else if (req_tready) begin
         hold_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         hold_data_ff <= req_tdata[NUM_FIELDS*FIELD_W-1:0];
      end
   end

   assign nrm = hold_data_ff[0*FIELD_W +: FIELD_W];
   assign va  = hold_data_ff[1*FIELD_W +: FIELD_W];
   assign vb  = hold_data_ff[2*FIELD_W +: FIELD_W];
   assign vc  = hold_data_ff[3*FIELD_W +: FIELD_W];
   assign vp  = hold_data_ff[4*FIELD_W +: FIELD_W];

   // Magnitudes fit CB unsigned bits, including the most negative value.
   assign n0 = nrm[CB-1]   ? -nrm[CB-1:0]      : nrm[CB-1:0];
   assign n1 = nrm[2*CB-1] ? -nrm[2*CB-1:CB]   : nrm[2*CB-1:CB];
   assign n2 = nrm[3*CB-1] ? -nrm[3*CB-1:2*CB] : nrm[3*CB-1:2*CB];

   // Ties go to the later axis.
   always_comb begin
      if (n0 > n1) begin
         ax = (n0 > n2) ? AXIS_X : AXIS_Z;
      end else begin
         ax = (n1 > n2) ? AXIS_Y : AXIS_Z;
      end
      unique case (ax)
         AXIS_X: begin
            i1 = AXIS_Y;
            i2 = AXIS_Z;
         end
         AXIS_Y: begin
            i1 = AXIS_Z;
            i2 = AXIS_X;
         end
         default: begin
            i1 = AXIS_X;
            i2 = AXIS_Y;
         end
      endcase
   end

   always_comb begin
      push_item.d1   = sub(comp(vp, i1), comp(va, i1));
      push_item.d2   = sub(comp(vp, i2), comp(va, i2));
      push_item.b1   = sub(comp(vb, i1), comp(va, i1));
      push_item.b2   = sub(comp(vb, i2), comp(va, i2));
      push_item.c1   = sub(comp(vc, i1), comp(va, i1));
      push_item.c2   = sub(comp(vc, i2), comp(va, i2));
      push_item.flat = (push_item.b1 == '0);
   end

endmodule

`default_nettype wire

// ===== hdl/pit_queue.sv =====
// ============================================================================
// pit_queue
// Small request queue that decouples the front from the back.
// ============================================================================
`default_nettype none

module pit_queue import pit_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push_valid,
   output logic      push_ready,
   input  item_type  push_item,
   input  wire logic pop,
   output logic      pop_valid,
   output item_type  pop_item
);

   item_type         mem_ff [QDEPTH];
   logic [QAW:0]     count_ff, count_in;
   logic [QAW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != (QAW+1)'(QDEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign count_in   = count_ff + (QAW+1)'(do_push) - (QAW+1)'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/pit_div.sv =====
// ============================================================================
// pit_div
// Pipelined restoring divider for u, one quotient bit per stage.
// ============================================================================
`default_nettype none

module pit_div import pit_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire logic          in_valid,
   input  wire logic [MW-1:0] un,
   input  wire logic [MW-1:0] ud,
   input  vctx_type           in_ctx,
   output logic               out_valid,
   output logic [QW-1:0]      mag,
   output vctx_type           out_ctx
);

   logic [F:0]      valid_ff;
   logic [MW-1:0]   rem_ff [F+1];
   logic [MW-1:0]   rem_in [F+1];
   logic [MW-1:0]   ud_ff  [F+1];
   logic [QW-1:0]   q_ff   [F+1];
   logic [QW-1:0]   q_in   [F+1];
   logic            sat_ff [F+1];
   vctx_type        ctx_ff [F+1];
   logic [MW:0]     r2     [F+1];
   logic            ge     [F+1];

   // The first stage settles the integer bit and the saturation at 2.0;
   // each later stage shifts the remainder and takes one fraction bit.
   always_comb begin
      r2[0]     = '0;
      ge[0]     = (un >= ud);
      rem_in[0] = ge[0] ? (un - ud) : un;
      q_in[0]   = {{(QW-1){1'b0}}, ge[0]};
      for (int k = 1; k <= F; k++) begin
         r2[k]     = {rem_ff[k-1], 1'b0};
         ge[k]     = (r2[k] >= {1'b0, ud_ff[k-1]});
         rem_in[k] = ge[k] ? MW'(r2[k] - {1'b0, ud_ff[k-1]}) : r2[k][MW-1:0];
         q_in[k]   = {q_ff[k-1][QW-2:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[F-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= rem_in[0];
         ud_ff[0]  <= ud;
         q_ff[0]   <= q_in[0];
         sat_ff[0] <= ({1'b0, un} >= {ud, 1'b0});
         ctx_ff[0] <= in_ctx;
         for (int k = 1; k <= F; k++) begin
            rem_ff[k] <= rem_in[k];
            ud_ff[k]  <= ud_ff[k-1];
            q_ff[k]   <= q_in[k];
            sat_ff[k] <= sat_ff[k-1];
            ctx_ff[k] <= ctx_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[F];
   assign mag       = sat_ff[F] ? SAT_MAG : q_ff[F];
   assign out_ctx   = ctx_ff[F];

endmodule

`default_nettype wire

// ===== hdl/pit_back.sv =====
// ============================================================================
// pit_back
// Solves for u and v and delivers the inside and degenerate flags.
// ============================================================================
`default_nettype none

module pit_back import pit_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             pop_valid,
   input  item_type              pop_item,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata
);

   logic en;

   // Stage 1: cross products.
   logic                 s1_valid_ff;
   logic                 s1_flat_ff;
   logic signed [PW-1:0] s1_p1_ff, s1_p2_ff, s1_q1_ff, s1_q2_ff;
   logic signed [DW-1:0] s1_d1_ff, s1_c1_ff;
   vctx_type             s1_ctx_ff, s1_ctx_in;

   // Stage 2: numerator and denominator of u.
   logic                 s2_valid_ff;
   logic signed [NW-1:0] s2_num_ff, s2_den_ff, s2_num_in, s2_den_in;
   vctx_type             s2_ctx_ff;

   // Stage 3: magnitudes for the divider.
   logic                 s3_valid_ff;
   logic [MW-1:0]        s3_un_ff, s3_ud_ff;
   vctx_type             s3_ctx_ff, s3_ctx_in;

   logic                 dv_valid;
   logic [QW-1:0]        dv_mag;
   vctx_type             dv_ctx;

   // Stage 4: range test of u and u times the edge component.
   logic                  s4_valid_ff, s4_uok_ff, s4_uok_in;
   logic [QW-1:0]         s4_mag_ff;
   logic signed [UCW-1:0] s4_uc_ff;
   vctx_type              s4_ctx_ff;

   // Stage 5: numerator of v and the bound ONE - u + 1.
   logic                 s5_valid_ff, s5_uok_ff;
   logic signed [VW-1:0] s5_numv_ff, s5_numv_in;
   logic [QW-1:0]        s5_w1_ff;
   logic [DW-1:0]        s5_babs_ff, s5_babs_in;
   vctx_type             s5_ctx_ff;

   // Stage 6: magnitudes and the bound product.
   logic                 s6_valid_ff, s6_uok_ff, s6_diff_ff, s6_nz_ff;
   logic [VW-1:0]        s6_nabs_ff;
   logic [DW-1:0]        s6_babs_ff;
   logic [PRW-1:0]       s6_prod_ff;
   vctx_type             s6_ctx_ff;

   // Result register.
   logic                 rsp_valid_ff;
   logic                 rsp_inside_ff, rsp_degen_ff;
   logic                 vneg, vle, inside_in, degen_in;

   assign en  = !rsp_valid_ff || rsp_tready;
   assign pop = en;

   always_comb begin
      s1_ctx_in.d       = pop_item.flat ? pop_item.d2 : pop_item.d1;
      s1_ctx_in.c       = pop_item.flat ? pop_item.c2 : pop_item.c1;
      s1_ctx_in.b       = pop_item.flat ? pop_item.b2 : pop_item.b1;
      s1_ctx_in.flat_b0 = pop_item.flat && (pop_item.b2 == '0);
      s1_ctx_in.neg     = 1'b0;
      s1_ctx_in.dz      = 1'b0;
   end

   // On the flat edge arm u is d1 / c1; otherwise Cramer's rule.
   always_comb begin
      if (s1_flat_ff) begin
         s2_num_in = {{(NW-DW){s1_d1_ff[DW-1]}}, s1_d1_ff};
         s2_den_in = {{(NW-DW){s1_c1_ff[DW-1]}}, s1_c1_ff};
      end else begin
         s2_num_in = {s1_p1_ff[PW-1], s1_p1_ff} - {s1_p2_ff[PW-1], s1_p2_ff};
         s2_den_in = {s1_q1_ff[PW-1], s1_q1_ff} - {s1_q2_ff[PW-1], s1_q2_ff};
      end
   end

   always_comb begin
      s3_ctx_in     = s2_ctx_ff;
      s3_ctx_in.neg = s2_num_ff[NW-1] ^ s2_den_ff[NW-1];
      s3_ctx_in.dz  = (s2_den_ff == '0);
   end

   // A negative u that truncates to zero still passes.
   assign s4_uok_in = (!dv_ctx.neg || dv_mag == '0) && (dv_mag <= ONE_Q);

   assign s5_numv_in = {{(VW-DW-F){s4_ctx_ff.d[DW-1]}}, s4_ctx_ff.d, {F{1'b0}}}
                       - {s4_uc_ff[UCW-1], s4_uc_ff};
   assign s5_babs_in = s4_ctx_ff.b[DW-1] ? DW'(-s4_ctx_ff.b) : DW'(s4_ctx_ff.b);

   // v = trunc(numv / b). v < 0 only when the signs differ and |numv| >= |b|.
   // v <= ONE - u holds when the quotient is negative, or |numv| < (ONE-u+1)|b|.
   always_comb begin
      vneg      = s6_diff_ff && s6_nz_ff &&
                  (s6_nabs_ff >= {{(VW-DW){1'b0}}, s6_babs_ff});
      vle       = (s6_diff_ff && s6_nz_ff) ||
                  (s6_nabs_ff < {{(VW-PRW){1'b0}}, s6_prod_ff});
      degen_in  = s6_ctx_ff.dz || (s6_uok_ff && s6_ctx_ff.flat_b0);
      inside_in = !s6_ctx_ff.dz && s6_uok_ff && !s6_ctx_ff.flat_b0 && !vneg && vle;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= pop_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= dv_valid;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         rsp_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_flat_ff <= pop_item.flat;
         s1_p1_ff   <= pop_item.d2 * pop_item.b1;
         s1_p2_ff   <= pop_item.d1 * pop_item.b2;
         s1_q1_ff   <= pop_item.c2 * pop_item.b1;
         s1_q2_ff   <= pop_item.c1 * pop_item.b2;
         s1_d1_ff   <= pop_item.d1;
         s1_c1_ff   <= pop_item.c1;
         s1_ctx_ff  <= s1_ctx_in;

         s2_num_ff  <= s2_num_in;
         s2_den_ff  <= s2_den_in;
         s2_ctx_ff  <= s1_ctx_ff;

         s3_un_ff   <= s2_num_ff[NW-1] ? MW'(-s2_num_ff) : MW'(s2_num_ff);
         s3_ud_ff   <= s2_den_ff[NW-1] ? MW'(-s2_den_ff) : MW'(s2_den_ff);
         s3_ctx_ff  <= s3_ctx_in;

         s4_uok_ff  <= s4_uok_in;
         s4_mag_ff  <= dv_mag;
         s4_uc_ff   <= $signed({1'b0, dv_mag}) * dv_ctx.c;
         s4_ctx_ff  <= dv_ctx;

         s5_uok_ff  <= s4_uok_ff;
         s5_numv_ff <= s5_numv_in;
         s5_w1_ff   <= ONE_Q + QW'(1) - s4_mag_ff;
         s5_babs_ff <= s5_babs_in;
         s5_ctx_ff  <= s4_ctx_ff;

         s6_uok_ff  <= s5_uok_ff;
         s6_diff_ff <= s5_numv_ff[VW-1] ^ s5_ctx_ff.b[DW-1];
         s6_nz_ff   <= (s5_numv_ff != '0);
         s6_nabs_ff <= s5_numv_ff[VW-1] ? VW'(-s5_numv_ff) : VW'(s5_numv_ff);
         s6_babs_ff <= s5_babs_ff;
         s6_prod_ff <= s5_w1_ff * s5_babs_ff;
         s6_ctx_ff  <= s5_ctx_ff;

         rsp_inside_ff <= inside_in;
         rsp_degen_ff  <= degen_in;
      end
   end

   pit_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_valid_ff),
      .un        (s3_un_ff),
      .ud        (s3_ud_ff),
      .in_ctx    (s3_ctx_ff),
      .out_valid (dv_valid),
      .mag       (dv_mag),
      .out_ctx   (dv_ctx)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-2){1'b0}}, rsp_degen_ff, rsp_inside_ff};

endmodule

`default_nettype wire

// ===== hdl/point_in_triangle_test.sv =====
// ============================================================================
// point_in_triangle_test
// Projected barycentric point-in-triangle test with a pipelined divider.
// ============================================================================
// Each request on the req_ channel carries a plane normal, vertices A, B, C
// and a query point, each as three 20-bit signed components. The block drops
// the axis where the normal is largest, solves for the edge coordinates u and
// v in the remaining plane and returns one response per request on the rsp_
// channel: bit 0 is set when the point lies inside or on the triangle, bit 1
// when a zero divisor was met (the inside bit is then clear).
// Throughput is one request per clock while rsp_tready is high. A request
// passes through a holding register, a four-entry queue, three setup
// stages, the u divider with one stage per quotient bit, and four stages
// for the v bounds test. The front stage and the queue keep accepting
// requests while the back end is held by a stalled receiver; once the
// queue and the holding register are full, req_tready drops. While a
// response is pending and rsp_tready is low, the whole back pipeline
// freezes and the pending response holds steady. Reset clears all valid
// state and the queue; the block takes a request as soon as reset is released.
// ============================================================================
`default_nettype none

module point_in_triangle_test import pit_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // normal_vec[59:0], vertex_a[119:60], vertex_b[179:120],
   // vertex_c[239:180], query_point[299:240], zero fill above.
   input  wire logic [REQ_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   // inside_res[0], degenerate[1], zero fill above.
   output logic [RSP_W-1:0]      rsp_tdata
);

   logic     push_valid, push_ready;
   item_type push_item;
   logic     pop, pop_valid;
   item_type pop_item;

   // The front classifies each request: it picks the projection axes, forms
   // the vertex differences and marks the flat edge case.
   pit_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // The queue lets the front keep taking requests while the back is held.
   pit_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item)
   );

   // The back solves for u through the divider and tests v without dividing.
   pit_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== dv/point_in_triangle_test_tb.sv =====
// ============================================================================
// point_in_triangle_test_tb
// Self-checking testbench for the projected point-in-triangle test.
// ============================================================================
// A driver feeds requests from a queue of pending geometry and a monitor
// compares each response with the classification that the testbench predicts
// for the request, in order. Both sides idle in random bursts, except during
// the last part of the run. A watchdog ends the run if nothing moves.
// ============================================================================
`default_nettype none

module point_in_triangle_test_tb;
   import pit_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_REQUESTS = 1800;
   localparam int QUIET_TAIL      = 200;
   localparam int STALL_LIMIT     = 2000;
   localparam int DRAIN_CYCLES    = 60;

   typedef struct packed {
      logic [FIELD_W-1:0] normal_vec;
      logic [FIELD_W-1:0] vertex_a;
      logic [FIELD_W-1:0] vertex_b;
      logic [FIELD_W-1:0] vertex_c;
      logic [FIELD_W-1:0] query_point;
   } geometry_type;

   typedef struct packed {
      logic inside_res;
      logic degenerate;
   } verdict_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   geometry_type pending_geometry[$];
   verdict_type  expected_verdicts[$];
   int        mismatches = 0;
   int        requests_total = 0;
   int        requests_sent = 0;
   int        idle_cycles = 0;
   int        send_gap = 0;
   int        recv_gap = 0;
   bit        stimulus_done = 1'b0;

   always #2 clock = ~clock;

   point_in_triangle_test dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Signed component k of a packed vector, sign-extended to 64 bits.
   function automatic longint component(input logic [FIELD_W-1:0] w, input int k);
      logic signed [CB-1:0] c;
      c = w[k*CB +: CB];
      return longint'(c);
   endfunction

   // Quotient with F fraction bits, truncated toward zero, magnitude capped at 2.0.
   function automatic longint fixed_quotient(input longint num, input longint den);
      longint un, ud, whole, rem, mag;
      bit     neg;
      neg = (num < 0) != (den < 0);
      un = (num < 0) ? -num : num;
      ud = (den < 0) ? -den : den;
      whole = un / ud;
      rem = un % ud;
      if (whole >= 2) begin
         mag = longint'(2) << F;
      end else begin
         mag = whole;
         for (int s = 0; s < F; s++) begin
            rem = rem << 1;
            mag = mag << 1;
            if (rem >= ud) begin
               rem -= ud;
               mag |= 1;
            end
         end
      end
      return neg ? -mag : mag;
   endfunction

   function automatic verdict_type classify_point(input geometry_type g);
      verdict_type r;
      longint   n0, n1, n2, d1, d2, b1, b2, c1, c2, u, v, num, den, one;
      int       ax, i1, i2;
      one = longint'(1) << F;
      r = '0;
      n0 = component(g.normal_vec, 0);
      n1 = component(g.normal_vec, 1);
      n2 = component(g.normal_vec, 2);
      if (n0 < 0) n0 = -n0;
      if (n1 < 0) n1 = -n1;
      if (n2 < 0) n2 = -n2;
      // Drop the dominant axis of the normal; ties go to the later axis.
      if (n0 > n1) ax = (n0 > n2) ? 0 : 2;
      else ax = (n1 > n2) ? 1 : 2;
      i1 = (ax + 1) % 3;
      i2 = (ax + 2) % 3;
      d1 = component(g.query_point, i1) - component(g.vertex_a, i1);
      d2 = component(g.query_point, i2) - component(g.vertex_a, i2);
      b1 = component(g.vertex_b, i1) - component(g.vertex_a, i1);
      b2 = component(g.vertex_b, i2) - component(g.vertex_a, i2);
      c1 = component(g.vertex_c, i1) - component(g.vertex_a, i1);
      c2 = component(g.vertex_c, i2) - component(g.vertex_a, i2);
      if (b1 == 0) begin
         // Edge AB is flat on the first kept axis: solve the axes one by one.
         if (c1 == 0) begin
            r.degenerate = 1'b1;
         end else begin
            u = fixed_quotient(d1, c1);
            if (u >= 0 && u <= one) begin
               if (b2 == 0) begin
                  r.degenerate = 1'b1;
               end else begin
                  num = d2 * one - u * c2;
                  v = num / b2;
                  r.inside_res = (v >= 0 && u + v <= one);
               end
            end
         end
      end else begin
         den = c2 * b1 - c1 * b2;
         if (den == 0) begin
            r.degenerate = 1'b1;
         end else begin
            u = fixed_quotient(d2 * b1 - d1 * b2, den);
            if (u >= 0 && u <= one) begin
               num = d1 * one - u * c1;
               v = num / b1;
               r.inside_res = (v >= 0 && u + v <= one);
            end
         end
      end
      return r;
   endfunction

   function automatic logic [FIELD_W-1:0] pack_vec(input int x, input int y, input int z);
      logic [CB-1:0] cx, cy, cz;
      cx = CB'(x);
      cy = CB'(y);
      cz = CB'(z);
      return {cz, cy, cx};
   endfunction

   function automatic logic [FIELD_W-1:0] random_vec();
      return FIELD_W'({$urandom(), $urandom()});
   endfunction

   // A component with small magnitude most of the time and any value now and then.
   function automatic int coord();
      if ($urandom_range(9) == 0) return int'($urandom_range(20'hFFFFF)) - (1 << 19);
      return int'($urandom_range(400)) - 200;
   endfunction

   task automatic add_request(input geometry_type g);
      pending_geometry.push_back(g);
      requests_total++;
   endtask

   // Triangle with P = A + s*(C-A) + t*(B-A), s and t in eighths, sometimes
   // sharing coordinates with A so the flat-edge path and zero divisors appear.
   task automatic add_shaped_request();
      geometry_type g;
      int ax, ay, az, bx, by, bz, cx, cy, cz, s, t;
      ax = coord(); ay = coord(); az = coord();
      bx = ax + int'($urandom_range(200)) - 100;
      by = ay + int'($urandom_range(200)) - 100;
      bz = az + int'($urandom_range(200)) - 100;
      cx = ax + int'($urandom_range(200)) - 100;
      cy = ay + int'($urandom_range(200)) - 100;
      cz = az + int'($urandom_range(200)) - 100;
      case ($urandom_range(5))
         0: begin bx = ax; by = ay; bz = az; end
         1: begin bx = ax; end
         2: begin by = ay; bz = az; end
         3: begin cx = ax; cy = ay; cz = az; end
         default: ;
      endcase
      s = int'($urandom_range(12)) - 2;
      t = int'($urandom_range(12)) - 2;
      g.vertex_a = pack_vec(ax, ay, az);
      g.vertex_b = pack_vec(bx, by, bz);
      g.vertex_c = pack_vec(cx, cy, cz);
      g.query_point = pack_vec(ax + (s * (cx - ax) + t * (bx - ax)) / 8 + int'($urandom_range(2)) - 1,
                               ay + (s * (cy - ay) + t * (by - ay)) / 8 + int'($urandom_range(2)) - 1,
                               az + (s * (cz - az) + t * (bz - az)) / 8 + int'($urandom_range(2)) - 1);
      g.normal_vec = ($urandom_range(3) == 0) ? random_vec()
                     : pack_vec(coord(), coord(), coord());
      add_request(g);
   endtask

   initial begin
      geometry_type g;
      int mx, mn;
      mx = (1 << 19) - 1;
      mn = -(1 << 19);
      // Directed part: for each axis, vertices in the plane across that axis and a normal largest on it.
      for (int ax = 0; ax < 3; ax++) begin
         g.normal_vec = pack_vec(ax == 0 ? 5 : 1, ax == 1 ? 5 : 1, ax == 2 ? 5 : 1);
         g.vertex_a = pack_vec(0, 0, 0);
         g.vertex_b = pack_vec(ax == 0 ? 0 : 256, ax == 0 ? 256 : 0, ax == 2 ? 0 : 256);
         g.vertex_c = pack_vec(ax == 1 ? 256 : 0, ax == 1 ? 0 : 256, ax == 2 ? 0 : 256);
         g.query_point = pack_vec(40, 40, 40);
         add_request(g);
         g.query_point = pack_vec(300, 300, 300);
         add_request(g);
      end
      // Ties in the normal magnitude, including all equal and all zero, and a near tie at the extremes.
      g.vertex_a = pack_vec(0, 0, 0);
      g.vertex_b = pack_vec(100, 0, 7);
      g.vertex_c = pack_vec(3, 100, 0);
      g.query_point = pack_vec(10, 10, 10);
      g.normal_vec = pack_vec(0, 0, 0);               add_request(g);
      g.normal_vec = pack_vec(-9, 9, 9);              add_request(g);
      g.normal_vec = pack_vec(9, -9, 2);              add_request(g);
      g.normal_vec = pack_vec(mn, mx, 0);             add_request(g);
      // Point on a vertex, first on B and then on C.
      g.normal_vec = pack_vec(0, 0, 1);
      g.query_point = pack_vec(100, 0, 0);            add_request(g);
      g.query_point = pack_vec(3, 100, 0);            add_request(g);
      // Zero divisor on the normal arm: collinear vertices.
      g.vertex_b = pack_vec(10, 10, 0);
      g.vertex_c = pack_vec(20, 20, 0);               add_request(g);
      // Flat edge arm, inside and with a zero divisor for u and for v.
      g.normal_vec = pack_vec(0, 0, 1);
      g.vertex_b = pack_vec(0, 100, 0);
      g.vertex_c = pack_vec(100, 0, 0);
      g.query_point = pack_vec(20, 20, 0);            add_request(g);
      g.vertex_c = pack_vec(0, 50, 0);                add_request(g);
      g.vertex_b = pack_vec(0, 0, 0);
      g.vertex_c = pack_vec(100, 0, 0);               add_request(g);
      // Large u saturates; a tiny negative quotient truncates to zero.
      g.vertex_b = pack_vec(0, 1, 0);
      g.vertex_c = pack_vec(1, 0, 0);
      g.query_point = pack_vec(mx, 0, 0);             add_request(g);
      g.vertex_b = pack_vec(1, 1000, 0);
      g.vertex_c = pack_vec(mx, 0, 0);
      g.query_point = pack_vec(0, 1, 0);              add_request(g);
      // Extremes of every field, with all bits set and all clear.
      g.normal_vec = '1; g.vertex_a = '1; g.vertex_b = '0; g.vertex_c = '1;
      g.query_point = '0;                              add_request(g);
      g.normal_vec = pack_vec(mn, mn, mn);
      g.vertex_a = pack_vec(mn, mn, mn);
      g.vertex_b = pack_vec(mx, mx, mn);
      g.vertex_c = pack_vec(mn, mx, mx);
      g.query_point = pack_vec(mx, mx, mx);            add_request(g);
      g.vertex_a = pack_vec(mx, mx, mx);
      g.vertex_b = pack_vec(mn, mx, mx);
      g.vertex_c = pack_vec(mx, mn, mn);
      g.query_point = pack_vec(mn, mn, mn);            add_request(g);
      // Random part: mostly shaped triangles, the rest fully random noise.
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if ($urandom_range(4) == 0) begin
            g.normal_vec = random_vec(); g.vertex_a = random_vec();
            g.vertex_b = random_vec(); g.vertex_c = random_vec();
            g.query_point = random_vec();
            add_request(g);
         end else begin
            add_shaped_request();
         end
      end
      stimulus_done = 1'b1;
   end

   // Driver. The request is held until accepted, then the next one is
   // loaded in the same step so tvalid never dips between back-to-back items.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) requests_sent++;
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_geometry.size() > 0) begin
            if (requests_total - requests_sent > QUIET_TAIL && $urandom_range(15) == 0) begin
               send_gap <= $urandom_range(18, 1);
               req_tvalid <= 1'b0;
            end else begin
               geometry_type g;
               g = pending_geometry.pop_front();
               expected_verdicts.push_back(classify_point(g));
               req_tdata <= {{(REQ_W - NUM_FIELDS * FIELD_W){1'b0}}, g.query_point,
                             g.vertex_c, g.vertex_b, g.vertex_a, g.normal_vec};
               req_tvalid <= 1'b1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor and receiver back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            verdict_type got, want;
            got.inside_res = rsp_tdata[0];
            got.degenerate = rsp_tdata[1];
            if (expected_verdicts.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected response %b with no request outstanding", rsp_tdata);
            end else begin
               want = expected_verdicts.pop_front();
               if (got.inside_res !== want.inside_res || got.degenerate !== want.degenerate ||
                   rsp_tdata[RSP_W-1:2] !== '0) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Response mismatch: inside %b/%b degenerate %b/%b (expected/actual)",
                              want.inside_res, got.inside_res, want.degenerate, got.degenerate);
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_tready <= 1'b0;
         end else if (requests_total - requests_sent > QUIET_TAIL && $urandom_range(15) == 0) begin
            recv_gap <= $urandom_range(18, 1);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: counts cycles in which neither channel moves.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      fork
         begin
            wait (stimulus_done && pending_geometry.size() == 0 &&
                  !req_tvalid && expected_verdicts.size() == 0);
            repeat (DRAIN_CYCLES) @(posedge clock);
            if (mismatches == 0 && expected_verdicts.size() == 0)
               $display("Testbench completed without errors");
            else
               $display("Testbench completed WITH ERRORS");
         end
         begin
            wait (idle_cycles >= STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
         end
      join_any
      $finish;
   end

endmodule

`default_nettype wire

// ===== point_in_triangle_test.f =====
hdl/pit_pkg.sv
hdl/pit_front.sv
hdl/pit_queue.sv
hdl/pit_div.sv
hdl/pit_back.sv
hdl/point_in_triangle_test.sv
dv/point_in_triangle_test_tb.sv
